/* rtl/mu8dh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mu8dh_pkg
// Shared types and constants of the modified UTF-8 decoder with string hash.
// ----------------------------------------------------------------------------
package mu8dh_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CharW  = 16;
  localparam int unsigned HashW  = 32;
  localparam int unsigned CountW = 16;

  localparam logic [ByteW-1:0]  ByteEnd    = 8'h00;
  localparam logic [CountW-1:0] CountMax   = 16'hffff;

  // pending continuation bytes
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;
  localparam logic [1:0] PendBad  = 2'd3;

  // result kinds
  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef struct packed {
    logic [1:0]        bytes_pending;
    logic [CharW-1:0]  partial_char;
    logic [HashW-1:0]  running_hash;
    logic [CountW-1:0] chars_seen;
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [CharW-1:0]  char_value;
    logic [HashW-1:0]  hash_value;
    logic [CountW-1:0] char_count;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } step_res_t;

endpackage

/* rtl/mu8dh_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mu8dh_if
// Request channels of the decoder: input bytes and results.
// ----------------------------------------------------------------------------
interface mu8dh_byte_if import mu8dh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface mu8dh_res_if import mu8dh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CharW-1:0]  char_value;
  logic [HashW-1:0]  hash_value;
  logic [CountW-1:0] char_count;

  modport source (output valid, output kind, output char_value, output hash_value,
                  output char_count, input ready);
  modport sink   (input valid, input kind, input char_value, input hash_value,
                  input char_count, output ready);
endinterface

/* rtl/mu8dh_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mu8dh_step
// Decodes one byte against the current state: next state and optional result.
// ----------------------------------------------------------------------------
module mu8dh_step import mu8dh_pkg::*; (
  input  state_t           state_i,
  input  logic [ByteW-1:0] byte_i,
  output state_t           state_o,
  output step_res_t        step_o
);

  logic             finish;
  logic [CharW-1:0] ch;
  logic [HashW-1:0] ch_ext;
  logic [HashW-1:0] hash_next;
  logic [CountW-1:0] count_next;

  always_comb begin
    state_o  = state_i;
    finish   = 1'b0;
    ch       = '0;
    step_o   = '0;
    unique case (state_i.bytes_pending)
      PendNone: begin
        if (byte_i == ByteEnd) begin
          step_o.emit           = 1'b1;
          step_o.res.kind       = KindEnd;
          step_o.res.hash_value = state_i.running_hash;
          step_o.res.char_count = state_i.chars_seen;
          state_o.running_hash  = '0;
          state_o.chars_seen    = '0;
        end else if (!byte_i[7]) begin
          finish = 1'b1;
          ch     = {8'h00, byte_i};
        end else if (byte_i[5]) begin
          state_o.partial_char  = {byte_i[3:0], 12'h000};
          state_o.bytes_pending = PendTwo;
        end else begin
          state_o.partial_char  = {5'b00000, byte_i[4:0], 6'b000000};
          state_o.bytes_pending = PendOne;
        end
      end
      PendTwo: begin
        state_o.partial_char  = state_i.partial_char | {4'h0, byte_i[5:0], 6'b000000};
        state_o.bytes_pending = PendOne;
      end
      PendOne, PendBad: begin
        finish                = 1'b1;
        ch                    = state_i.partial_char | {10'b0000000000, byte_i[5:0]};
        state_o.partial_char  = '0;
        state_o.bytes_pending = PendNone;
      end
      default: begin
        state_o = state_i;
      end
    endcase

    // hash * 37 as shifts and adds
    ch_ext     = {{(HashW-CharW){ch[CharW-1]}}, ch};
    hash_next  = (state_i.running_hash << 5) + (state_i.running_hash << 2)
               + state_i.running_hash + ch_ext;
    count_next = (state_i.chars_seen == CountMax) ? CountMax
               : state_i.chars_seen + 16'd1;

    if (finish) begin
      state_o.running_hash  = hash_next;
      state_o.chars_seen    = count_next;
      step_o.emit           = 1'b1;
      step_o.res.kind       = KindChar;
      step_o.res.char_value = ch;
      step_o.res.hash_value = hash_next;
      step_o.res.char_count = count_next;
    end
  end

endmodule

/* rtl/modified_utf8_decode_hash_core.sv */
`timescale 1ns / 1ps
// a completed result is registered in the output register, or in the skid entry while the output waits
// throughput: one byte per cycle while the skid entry is empty; the decode state updates in the accepting cycle
// an output register plus one skid entry lets input run while a result waits
// reset clears the decode state, hash, count and both output valid flags
// ----------------------------------------------------------------------------
// modified_utf8_decode_hash_core
// Modified UTF-8 decoder with running 32-bit string hash and character count.
// ----------------------------------------------------------------------------
module modified_utf8_decode_hash_core import mu8dh_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mu8dh_byte_if.sink   in_i,
  mu8dh_res_if.source  out_o
);

  state_t    state_q, state_d;
  step_res_t step;
  result_t   out_q, out_d, skid_q, skid_d;
  logic      out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic      acc, push, out_pop, out_free;

  mu8dh_step u_step (
    .state_i (state_q),
    .byte_i  (in_i.byte_in),
    .state_o (state_d),
    .step_o  (step)
  );

  assign in_i.ready = !skid_valid_q;
  assign acc        = in_i.valid && in_i.ready;
  assign push       = acc && step.emit;
  assign out_pop    = out_valid_q && out_o.ready;
  assign out_free   = !out_valid_q || out_pop;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_pop) begin
      out_valid_d = 1'b0;
    end
    if (skid_valid_q && out_free) begin
      out_d        = skid_q;
      out_valid_d  = 1'b1;
      skid_valid_d = 1'b0;
    end
    if (push) begin
      if (out_free) begin
        out_d       = step.res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = step.res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        state_q <= state_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.char_value = out_q.char_value;
  assign out_o.hash_value = out_q.hash_value;
  assign out_o.char_count = out_q.char_count;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && step.res.kind == KindEnd) |=>
      (state_q.running_hash == '0 && state_q.chars_seen == '0))
    else $error("hash or count not cleared after end of string");

  a_emit_idle_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (state_q.bytes_pending == PendNone))
    else $error("result emitted with a sequence still pending");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && step.res.kind == KindChar) |=> (state_q.chars_seen != '0))
    else $error("character count zero after a decoded character");
`endif

endmodule

/* verif/tb_modified_utf8_decode_hash_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modified_utf8_decode_hash_core
// Feeds modified UTF-8 byte strings into the decoder and decodes them again
// in a behavioral model alongside it. Each result request is compared field by
// field with the model. The stimulus covers edge-case sequences,
// random strings with noise and a long output hold.
// ----------------------------------------------------------------------------
module tb_modified_utf8_decode_hash_core;
  import mu8dh_pkg::*;

  localparam int unsigned MaxShown   = 10;
  localparam int unsigned DrainLimit = 4000;
  localparam int unsigned RandBytes  = 1820;

  logic clk;
  logic rst_n;

  mu8dh_byte_if byte_ch ();
  mu8dh_res_if  res_ch ();

  modified_utf8_decode_hash_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (res_ch)
  );

  // model state
  logic [1:0]        dec_pending = PendNone;
  logic [CharW-1:0]  dec_partial = '0;
  logic [HashW-1:0]  str_hash    = '0;
  logic [CountW-1:0] str_count   = '0;

  result_t     decoded_q[$];
  result_t     check_r;
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned burst_left     = 0;
  bit          sender_gaps    = 1'b0;
  bit          rx_stalls      = 1'b0;
  int unsigned hold_req       = 0;
  int unsigned hold_left      = 0;
  int unsigned pat_cnt        = 0;
  int unsigned pat_period     = 1;
  int unsigned pat_low        = 0;

  always #6 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MaxShown) $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b);
    result_t          r;
    logic [CharW-1:0] ch;
    bit               done;
    r    = '0;
    ch   = '0;
    done = 1'b0;
    if (dec_pending == PendNone) begin
      if (b == ByteEnd) begin
        r.kind       = KindEnd;
        r.hash_value = str_hash;
        r.char_count = str_count;
        decoded_q.push_back(r);
        str_hash  = '0;
        str_count = '0;
      end else if (!b[7]) begin
        ch   = {8'h00, b};
        done = 1'b1;
      end else if (b[5]) begin
        dec_partial = {b[3:0], 12'h000};
        dec_pending = PendTwo;
      end else begin
        dec_partial = {5'b0, b[4:0], 6'b0};
        dec_pending = PendOne;
      end
    end else if (dec_pending == PendTwo) begin
      dec_partial = dec_partial | {4'b0, b[5:0], 6'b0};
      dec_pending = PendOne;
    end else begin
      // one pending, or the unreachable three, completes the character
      ch          = dec_partial | {10'b0, b[5:0]};
      dec_partial = '0;
      dec_pending = PendNone;
      done        = 1'b1;
    end
    if (done) begin
      str_hash = str_hash * 32'd37 + {{16{ch[15]}}, ch};
      if (str_count != CountMax) str_count++;
      r.kind       = KindChar;
      r.char_value = ch;
      r.hash_value = str_hash;
      r.char_count = str_count;
      decoded_q.push_back(r);
    end
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      if (sender_gaps) begin
        gap = $urandom_range(1, 8);
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(b);
    bytes_sent++;
    burst_left--;
  endtask

  function automatic logic [ByteW-1:0] rand_cont();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 8'h00;
    if (pick < 3) return 8'($urandom_range(0, 255));
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  function automatic logic [ByteW-1:0] rand_lead(input bit three);
    logic [ByteW-1:0] r;
    r = 8'($urandom_range(0, 255));
    return {1'b1, r[6], three, r[4:0]};
  endfunction

  task automatic send_char();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      send_byte(8'($urandom_range(1, 127)));
    end else if (sel < 7) begin
      send_byte(rand_lead(1'b0));
      send_byte(rand_cont());
    end else begin
      send_byte(rand_lead(1'b1));
      send_byte(rand_cont());
      send_byte(rand_cont());
    end
  endtask

  task automatic wait_drain();
    int unsigned waited;
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    waited     = 0;
    while (decoded_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (decoded_q.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
      decoded_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    sender_gaps = 1'b1;
    rx_stalls   = 1'b1;
    // empty string straight after reset
    send_byte(ByteEnd);
    // single byte characters
    send_byte(8'h41);
    send_byte(8'h01);
    send_byte(8'h7f);
    send_byte(ByteEnd);
    // two byte sequences, zero inside a sequence, bad continuation prefix
    send_byte(8'hc0);
    send_byte(8'h80);
    send_byte(8'hdf);
    send_byte(8'hbf);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(ByteEnd);
    // three byte sequences, top of range gives a negative hash term
    send_byte(8'he0);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(8'hef);
    send_byte(8'hbf);
    send_byte(8'hbf);
    send_byte(8'ha8);
    send_byte(8'hc0);
    send_byte(8'h01);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(ByteEnd);
    wait_drain();
  endtask

  task automatic test_random_strings();
    int unsigned first;
    int unsigned n;
    first = bytes_sent;
    while (bytes_sent - first < RandBytes) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      rx_stalls   = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 20);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(0, 24);
        repeat (n) send_char();
        // truncated sequence swallows the terminator
        if ($urandom_range(0, 9) == 0) send_byte(rand_lead(1'($urandom_range(0, 1))));
        send_byte(ByteEnd);
      end
    end
    wait_drain();
  endtask

  task automatic test_output_hold();
    sender_gaps = 1'b0;
    rx_stalls   = 1'b0;
    hold_req    = 300;
    repeat (30) send_byte(8'($urandom_range(1, 127)));
    send_byte(ByteEnd);
    rx_stalls = 1'b1;
    hold_req  = 150;
    repeat (12) send_char();
    send_byte(ByteEnd);
    wait_drain();
  endtask

  // receiver: long holds on request, otherwise always ready, or an on/off pattern while stalls are enabled
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left--;
    end else if (!rx_stalls) begin
      res_ch.ready <= 1'b1;
    end else begin
      if (pat_cnt == 0) begin
        pat_period = $urandom_range(2, 12);
        pat_low    = $urandom_range(1, pat_period - 1);
      end
      res_ch.ready <= (pat_cnt >= pat_low);
      pat_cnt = (pat_cnt + 1 == pat_period) ? 0 : pat_cnt + 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind=%0d char=%h hash=%h count=%0d",
                                res_ch.kind, res_ch.char_value, res_ch.hash_value,
                                res_ch.char_count));
      end else begin
        check_r = decoded_q.pop_front();
        if (res_ch.kind !== check_r.kind || res_ch.char_value !== check_r.char_value ||
            res_ch.hash_value !== check_r.hash_value ||
            res_ch.char_count !== check_r.char_count) begin
          flag_mismatch($sformatf(
            "exp kind=%0d char=%h hash=%h count=%0d, got kind=%0d char=%h hash=%h count=%0d",
            check_r.kind, check_r.char_value, check_r.hash_value, check_r.char_count,
            res_ch.kind, res_ch.char_value, res_ch.hash_value, res_ch.char_count));
        end
      end
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.byte_in = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_strings();
    test_output_hold();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
